>>> design/dllm_pkg.sv
// shared types, field widths and operation codes of the linked list manager
package dllm_pkg;

   // field widths
   localparam int unsigned OP_W     = 3;
   localparam int unsigned HANDLE_W = 8;
   localparam int unsigned COUNT_W  = 8;

   // default highest node handle
   localparam int unsigned NODE_COUNT_DEF = 255;

   // largest handle the 8-bit fields can carry
   localparam int unsigned HANDLE_MAX = 255;

   // operation codes
   localparam logic [OP_W-1:0] OP_INS_TAIL  = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_HEAD  = 3'd1;
   localparam logic [OP_W-1:0] OP_REM_TAIL  = 3'd2;
   localparam logic [OP_W-1:0] OP_REM_HEAD  = 3'd3;
   localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd4;
   localparam logic [OP_W-1:0] OP_UNLINK    = 3'd5;

   // saturation limit of the element count
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // request transaction
   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [HANDLE_W-1:0] node;
      logic [HANDLE_W-1:0] anchor;
   } req_type;

   // response transaction
   typedef struct packed {
      logic                was_empty;
      logic                got_one;
      logic [HANDLE_W-1:0] removed_node;
      logic [COUNT_W-1:0]  element_count;
   } rsp_type;

endpackage

>>> design/dllm_ram.sv
// generic single write port, single read port ram with registered read
module dllm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents when the same entry is written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/dllm_engine.sv
// list engine: request decode, link memories, end pointers and count
module dllm_engine #(
   parameter int unsigned NODE_COUNT = dllm_pkg::NODE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dllm_pkg::req_type req_item,
   input  logic              stall,
   output logic              done,
   output dllm_pkg::rsp_type result
);

   localparam int unsigned HW = dllm_pkg::HANDLE_W;
   localparam int unsigned CW = dllm_pkg::COUNT_W;
   localparam int unsigned HANDLE_LIM =
      (NODE_COUNT < dllm_pkg::HANDLE_MAX) ? NODE_COUNT : dllm_pkg::HANDLE_MAX;
   localparam int unsigned LINK_DEPTH = HANDLE_LIM + 1;
   localparam int unsigned ADDR_W = $clog2(LINK_DEPTH);
   localparam logic [HW-1:0] LIM_H = HW'(HANDLE_LIM);

   // sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LINK = 1'b1;

   // action kinds
   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_UNLINK = 2'd2;

   logic          state_ff, state_in;
   logic [1:0]    act_ff, act_in;
   logic [HW-1:0] n_ff, n_in;
   logic [HW-1:0] at_ff, at_in;
   logic          was_empty_ff, was_empty_in;
   logic          got_one_ff, got_one_in;
   logic [HW-1:0] removed_ff, removed_in;
   logic [HW-1:0] first_ff, first_in;
   logic [HW-1:0] last_ff, last_in;
   logic [CW-1:0] count_ff, count_in;

   logic              accept, finish, empty, node_ok, anchor_ok;
   logic              nx_we, pv_we;
   logic [ADDR_W-1:0] nx_wa, pv_wa, nx_ra, pv_ra;
   logic [HW-1:0]     nx_wd, pv_wd, nx_rd, pv_rd;
   logic [HW-1:0]     after, prior;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == ST_LINK) && !stall;
   assign empty     = (first_ff == '0) && (last_ff == '0);
   assign node_ok   = (req_item.node != '0) && (req_item.node <= LIM_H);
   assign anchor_ok = (req_item.anchor <= LIM_H);

   // decode the request into an action, target node and anchor
   always_comb begin
      act_in       = act_ff;
      n_in         = n_ff;
      at_in        = at_ff;
      was_empty_in = was_empty_ff;
      got_one_in   = got_one_ff;
      removed_in   = removed_ff;
      if (accept) begin
         act_in       = ACT_NONE;
         n_in         = req_item.node;
         at_in        = '0;
         was_empty_in = 1'b0;
         got_one_in   = 1'b0;
         removed_in   = '0;
         case (req_item.op)
            dllm_pkg::OP_INS_TAIL, dllm_pkg::OP_INS_HEAD: begin
               if (node_ok) begin
                  act_in       = ACT_INSERT;
                  was_empty_in = empty;
                  at_in        = (req_item.op == dllm_pkg::OP_INS_TAIL) ? last_ff : '0;
               end
            end
            dllm_pkg::OP_REM_TAIL, dllm_pkg::OP_REM_HEAD: begin
               if (!empty) begin
                  act_in     = ACT_UNLINK;
                  got_one_in = 1'b1;
                  n_in       = (req_item.op == dllm_pkg::OP_REM_TAIL) ? last_ff : first_ff;
                  removed_in = n_in;
               end
            end
            dllm_pkg::OP_INS_AFTER: begin
               if (node_ok && anchor_ok) begin
                  act_in       = ACT_INSERT;
                  was_empty_in = empty;
                  at_in        = req_item.anchor;
               end
            end
            dllm_pkg::OP_UNLINK: begin
               if (node_ok) begin
                  act_in = ACT_UNLINK;
               end
            end
            default: begin
               act_in = ACT_NONE;
            end
         endcase
      end
   end

   // link memory read addresses, issued in the accept cycle
   assign nx_ra = (act_in == ACT_INSERT) ? at_in[ADDR_W-1:0] : n_in[ADDR_W-1:0];
   assign pv_ra = n_in[ADDR_W-1:0];

   // neighbors as seen before this operation
   assign after = (act_ff == ACT_INSERT && at_ff == '0) ? first_ff : nx_rd;
   assign prior = pv_rd;

   // at accept: own back and anchor fwd links, or own links; the rest at finish
   always_comb begin
      nx_we    = 1'b0;
      nx_wa    = n_ff[ADDR_W-1:0];
      nx_wd    = '0;
      pv_we    = 1'b0;
      pv_wa    = n_ff[ADDR_W-1:0];
      pv_wd    = '0;
      first_in = first_ff;
      last_in  = last_ff;
      count_in = count_ff;
      if (accept) begin
         if (act_in == ACT_INSERT) begin
            nx_we = (at_in != '0);
            nx_wa = at_in[ADDR_W-1:0];
            nx_wd = n_in;
            pv_we = 1'b1;
            pv_wa = n_in[ADDR_W-1:0];
            pv_wd = at_in;
         end else if (act_in == ACT_UNLINK) begin
            nx_we = 1'b1;
            nx_wa = n_in[ADDR_W-1:0];
            pv_we = 1'b1;
            pv_wa = n_in[ADDR_W-1:0];
         end
      end else if (finish) begin
         if (act_ff == ACT_INSERT) begin
            // own forward link, unless the anchor is the node itself
            nx_we = (at_ff != n_ff);
            nx_wa = n_ff[ADDR_W-1:0];
            nx_wd = after;
            if (after == '0) begin
               last_in = n_ff;
            end else begin
               pv_we = 1'b1;
               pv_wa = after[ADDR_W-1:0];
               pv_wd = n_ff;
            end
            if (at_ff == '0) begin
               first_in = n_ff;
            end
            if (count_ff != dllm_pkg::COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end else if (act_ff == ACT_UNLINK) begin
            // cleared own links win over a self neighbor
            if (prior == '0) begin
               first_in = after;
            end else if (prior != n_ff) begin
               nx_we = 1'b1;
               nx_wa = prior[ADDR_W-1:0];
               nx_wd = after;
            end
            if (after == '0) begin
               last_in = prior;
            end else if (after != n_ff) begin
               pv_we = 1'b1;
               pv_wa = after[ADDR_W-1:0];
               pv_wd = prior;
            end
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= '0;
         last_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

   // per-operation working registers
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      n_ff         <= n_in;
      at_ff        <= at_in;
      was_empty_ff <= was_empty_in;
      got_one_ff   <= got_one_in;
      removed_ff   <= removed_in;
   end

   // forward link table
   dllm_ram #(
      .WIDTH(HW),
      .DEPTH(LINK_DEPTH)
   ) u_next_ram (
      .clock  (clock),
      .wr_en  (nx_we),
      .wr_addr(nx_wa),
      .wr_data(nx_wd),
      .rd_en  (accept),
      .rd_addr(nx_ra),
      .rd_data(nx_rd)
   );

   // backward link table
   dllm_ram #(
      .WIDTH(HW),
      .DEPTH(LINK_DEPTH)
   ) u_prev_ram (
      .clock  (clock),
      .wr_en  (pv_we),
      .wr_addr(pv_wa),
      .wr_data(pv_wd),
      .rd_en  (accept),
      .rd_addr(pv_ra),
      .rd_data(pv_rd)
   );

   assign done                 = finish;
   assign result.was_empty     = was_empty_ff;
   assign result.got_one       = got_one_ff;
   assign result.removed_node  = removed_ff;
   assign result.element_count = count_in;

endmodule

>>> design/doubly_linked_list_manager.sv
// doubly linked list manager: top level with response register
//
//   channel   direction   ports                          transaction
//   req       in          req_valid req_ready req_item   one list operation
//   rsp       out         rsp_valid rsp_ready rsp_item   flags and element count
//
// each operation reads the link memories in the accept cycle and writes the
// neighbor links back in the link state that follows the accept.
// one operation is in flight at a time; the next request is taken while the
// previous response still waits in the response register.
// reset clears the end pointers and the count; link entries are not cleared.
// a held response stalls the link state of the next operation.
module doubly_linked_list_manager #(
   parameter int unsigned NODE_COUNT = dllm_pkg::NODE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dllm_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dllm_pkg::rsp_type rsp_item
);

   logic              rsp_valid_ff, rsp_valid_in;
   dllm_pkg::rsp_type rsp_item_ff, rsp_item_in;
   logic              out_busy;
   logic              done;
   dllm_pkg::rsp_type result;

   assign out_busy = rsp_valid_ff && !rsp_ready;

   dllm_engine #(
      .NODE_COUNT(NODE_COUNT)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .stall    (out_busy),
      .done     (done),
      .result   (result)
   );

   // response register
   assign rsp_valid_in = done || out_busy;
   assign rsp_item_in  = done ? result : rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   // a finished operation never overwrites a response still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> !out_busy)
      else $error("response overwritten while held");

   // one operation at a time: no request right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while operation in flight");

   // an insert result never reports a removal
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.was_empty && rsp_item.got_one))
      else $error("insert and removal flags both set");
`endif

endmodule

>>> tb/sv/doubly_linked_list_manager_tb.sv
// self-checking testbench of the doubly linked list manager
module doubly_linked_list_manager_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [dllm_pkg::HANDLE_W-1:0] handle_type;

   // op codes the block does not define
   localparam logic [dllm_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [dllm_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned SETTLE_TICKS = 10;
   localparam int unsigned MIXED_ITEMS  = 100;
   localparam int unsigned FILL_EXTRA   = 10;
   localparam int unsigned FILL_CAP     = 400;
   localparam int unsigned DRAIN_ITEMS  = 60;

   typedef enum int {MIXED, FILLING, DRAINING} load_mode_type;

   // one row of the directed sequence; want is used only when known is set
   typedef struct packed {
      dllm_pkg::req_type item;
      logic              known;
      dllm_pkg::rsp_type want;
   } plan_row_type;

   localparam dllm_pkg::rsp_type NO_CHANGE = '{1'b0, 1'b0, 8'd0, 8'd0};
   localparam dllm_pkg::rsp_type FIRST_IN  = '{1'b1, 1'b0, 8'd0, 8'd1};
   localparam dllm_pkg::rsp_type ANY_RSP   = '0;

   localparam int unsigned PLAN_LEN = 26;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // empty list, bad handles and spare op codes leave everything alone
      '{'{dllm_pkg::OP_REM_TAIL,  8'd0,   8'd0},   1'b1, NO_CHANGE},
      '{'{dllm_pkg::OP_REM_HEAD,  8'd255, 8'd255}, 1'b1, NO_CHANGE},
      '{'{dllm_pkg::OP_INS_TAIL,  8'd0,   8'd0},   1'b1, NO_CHANGE},
      '{'{dllm_pkg::OP_INS_AFTER, 8'd0,   8'd0},   1'b1, NO_CHANGE},
      '{'{dllm_pkg::OP_UNLINK,    8'd0,   8'd0},   1'b1, NO_CHANGE},
      '{'{OP_SPARE_A,             8'd17,  8'd0},   1'b1, NO_CHANGE},
      '{'{OP_SPARE_B,             8'd255, 8'd255}, 1'b1, NO_CHANGE},
      // build a short list with the extreme handles
      '{'{dllm_pkg::OP_INS_TAIL,  8'd255, 8'd0},   1'b1, FIRST_IN},
      '{'{dllm_pkg::OP_INS_HEAD,  8'd1,   8'd255}, 1'b1, '{1'b0, 1'b0, 8'd0, 8'd2}},
      '{'{dllm_pkg::OP_INS_AFTER, 8'd128, 8'd255}, 1'b0, ANY_RSP},
      '{'{dllm_pkg::OP_INS_AFTER, 8'd2,   8'd0},   1'b0, ANY_RSP},
      '{'{dllm_pkg::OP_UNLINK,    8'd128, 8'd0},   1'b0, ANY_RSP},
      // take it apart from both ends
      '{'{dllm_pkg::OP_REM_TAIL,  8'd0,   8'd0},   1'b0, ANY_RSP},
      '{'{dllm_pkg::OP_REM_HEAD,  8'd0,   8'd0},   1'b0, ANY_RSP},
      '{'{dllm_pkg::OP_REM_HEAD,  8'd99,  8'd0},   1'b0, ANY_RSP},
      '{'{dllm_pkg::OP_REM_HEAD,  8'd0,   8'd0},   1'b1, NO_CHANGE},
      // unlink of a node no longer on the list, count held at zero
      '{'{dllm_pkg::OP_UNLINK,    8'd1,   8'd0},   1'b1, NO_CHANGE},
      '{'{dllm_pkg::OP_INS_TAIL,  8'd7,   8'd0},   1'b1, FIRST_IN},
      '{'{dllm_pkg::OP_INS_TAIL,  8'd9,   8'd0},   1'b1, '{1'b0, 1'b0, 8'd0, 8'd2}},
      '{'{dllm_pkg::OP_UNLINK,    8'd7,   8'd0},   1'b0, ANY_RSP},
      '{'{dllm_pkg::OP_UNLINK,    8'd7,   8'd0},   1'b0, ANY_RSP},
      '{'{dllm_pkg::OP_UNLINK,    8'd7,   8'd0},   1'b1, NO_CHANGE},
      // head links cleared above, so the list reads as empty again
      '{'{dllm_pkg::OP_INS_TAIL,  8'd3,   8'd0},   1'b1, FIRST_IN},
      '{'{dllm_pkg::OP_INS_AFTER, 8'd9,   8'd3},   1'b0, ANY_RSP},
      '{'{dllm_pkg::OP_INS_TAIL,  8'd3,   8'd0},   1'b0, ANY_RSP},
      '{'{dllm_pkg::OP_REM_HEAD,  8'd0,   8'd0},   1'b0, ANY_RSP}
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   dllm_pkg::req_type req_item  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dllm_pkg::rsp_type rsp_item;

   doubly_linked_list_manager u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // list state as the block should hold it
   handle_type                   head_fwd     = '0;
   handle_type                   head_bwd     = '0;
   logic [dllm_pkg::COUNT_W-1:0] linked_count = '0;
   handle_type                   fwd_tab [256];
   handle_type                   bwd_tab [256];

   // stimulus bookkeeping: handles with written links, handles believed on the list
   bit         written [256];
   bit         on_list [256];
   handle_type member_q [$];

   dllm_pkg::rsp_type due_results [$];
   int unsigned       errors      = 0;
   int unsigned       issued      = 0;
   int unsigned       idle_cycles = 0;
   bit                calm        = 1'b0;

   function automatic handle_type fwd_of(input handle_type h);
      return (h == '0) ? head_fwd : fwd_tab[h];
   endfunction

   function automatic void set_fwd(input handle_type h, input handle_type v);
      if (h == '0) head_fwd = v;
      else fwd_tab[h] = v;
   endfunction

   function automatic void set_bwd(input handle_type h, input handle_type v);
      if (h == '0) head_bwd = v;
      else bwd_tab[h] = v;
   endfunction

   function automatic bit handle_ok(input handle_type h);
      return h >= 1 && h <= dllm_pkg::NODE_COUNT_DEF;
   endfunction

   function automatic bit list_empty();
      return head_fwd == '0 && head_bwd == '0;
   endfunction

   // link node n directly behind node at (0 is the head)
   function automatic void splice_in(input handle_type at, input handle_type n);
      handle_type nxt;
      nxt = fwd_of(at);
      fwd_tab[n] = nxt;
      bwd_tab[n] = at;
      set_bwd(nxt, n);
      set_fwd(at, n);
      if (linked_count != dllm_pkg::COUNT_MAX) linked_count++;
   endfunction

   // join the neighbors of node n and clear its own links
   function automatic void splice_out(input handle_type n);
      handle_type prv;
      handle_type nxt;
      prv = bwd_tab[n];
      nxt = fwd_tab[n];
      set_fwd(prv, nxt);
      set_bwd(nxt, prv);
      fwd_tab[n] = '0;
      bwd_tab[n] = '0;
      if (linked_count != '0) linked_count--;
   endfunction

   // apply one operation to the list state and return the response it gives
   function automatic dllm_pkg::rsp_type apply_list_op(input dllm_pkg::req_type r);
      dllm_pkg::rsp_type res;
      handle_type        victim;
      res = '0;
      case (r.op)
         dllm_pkg::OP_INS_TAIL, dllm_pkg::OP_INS_HEAD: begin
            if (handle_ok(r.node)) begin
               res.was_empty = list_empty();
               splice_in((r.op == dllm_pkg::OP_INS_TAIL) ? head_bwd : '0, r.node);
            end
         end
         dllm_pkg::OP_REM_TAIL, dllm_pkg::OP_REM_HEAD: begin
            if (!list_empty()) begin
               victim = (r.op == dllm_pkg::OP_REM_TAIL) ? head_bwd : head_fwd;
               res.got_one      = 1'b1;
               res.removed_node = victim;
               splice_out(victim);
            end
         end
         dllm_pkg::OP_INS_AFTER: begin
            if (handle_ok(r.node) && r.anchor <= dllm_pkg::NODE_COUNT_DEF) begin
               res.was_empty = list_empty();
               splice_in(r.anchor, r.node);
            end
         end
         dllm_pkg::OP_UNLINK: begin
            if (handle_ok(r.node)) splice_out(r.node);
         end
         default: ;
      endcase
      res.element_count = linked_count;
      return res;
   endfunction

   // never let the block read a link entry that was never written
   function automatic bit reads_only_written(input dllm_pkg::req_type r);
      case (r.op)
         dllm_pkg::OP_REM_TAIL:  return list_empty() || head_bwd != '0;
         dllm_pkg::OP_REM_HEAD:  return list_empty() || head_fwd != '0;
         dllm_pkg::OP_INS_AFTER: return r.anchor == '0 || written[r.anchor];
         dllm_pkg::OP_UNLINK:    return !handle_ok(r.node) || written[r.node];
         default:                return 1'b1;
      endcase
   endfunction

   function automatic void add_member(input handle_type h);
      if (!on_list[h]) begin
         on_list[h] = 1'b1;
         member_q.push_back(h);
      end
   endfunction

   function automatic void drop_member(input handle_type h);
      int hits [$];
      if (on_list[h]) begin
         on_list[h] = 1'b0;
         hits = member_q.find_first_index(x) with (x == h);
         if (hits.size() != 0) member_q.delete(hits[0]);
      end
   endfunction

   function automatic handle_type any_member();
      if (member_q.size() == 0) return '0;
      return member_q[$urandom_range(0, member_q.size() - 1)];
   endfunction

   // a handle not on the list, if a few tries find one
   function automatic handle_type pick_fresh();
      handle_type h;
      h = handle_type'($urandom_range(1, dllm_pkg::NODE_COUNT_DEF));
      for (int i = 0; i < 8 && on_list[h]; i++) begin
         h = handle_type'($urandom_range(1, dllm_pkg::NODE_COUNT_DEF));
      end
      return h;
   endfunction

   // random operation, mostly well-formed, with noise mixed in
   function automatic dllm_pkg::req_type pick_item(input load_mode_type mode);
      dllm_pkg::req_type r;
      int unsigned       roll;
      r.op     = dllm_pkg::OP_REM_HEAD;
      r.node   = handle_type'($urandom_range(0, dllm_pkg::HANDLE_MAX));
      r.anchor = handle_type'($urandom_range(0, dllm_pkg::HANDLE_MAX));
      roll     = $urandom_range(0, 99);
      if (mode == FILLING && roll < 95) roll = 0;
      else if (mode == DRAINING && roll < 80) roll = 40;
      else roll = $urandom_range(0, 99);

      if (roll < 24) begin
         r.op   = $urandom_range(0, 1) ? dllm_pkg::OP_INS_HEAD : dllm_pkg::OP_INS_TAIL;
         r.node = pick_fresh();
      end else if (roll < 38) begin
         r.op     = dllm_pkg::OP_INS_AFTER;
         r.node   = pick_fresh();
         r.anchor = ($urandom_range(0, 3) != 0) ? any_member() : '0;
      end else if (roll < 58) begin
         r.op = $urandom_range(0, 1) ? dllm_pkg::OP_REM_HEAD : dllm_pkg::OP_REM_TAIL;
      end else if (roll < 74) begin
         r.op   = dllm_pkg::OP_UNLINK;
         r.node = any_member();
         if (r.node == '0) r.op = dllm_pkg::OP_REM_TAIL;
      end else if (roll < 80) begin
         // unlink with whatever links the handle still holds
         r.op = dllm_pkg::OP_UNLINK;
         for (int i = 0; i < 16 && !written[r.node]; i++) begin
            r.node = handle_type'($urandom_range(1, dllm_pkg::HANDLE_MAX));
         end
      end else if (roll < 86) begin
         // insert of a handle already on the list
         case ($urandom_range(0, 2))
            0:       r.op = dllm_pkg::OP_INS_TAIL;
            1:       r.op = dllm_pkg::OP_INS_HEAD;
            default: r.op = dllm_pkg::OP_INS_AFTER;
         endcase
         r.node = any_member();
         if (r.node == '0) r.node = pick_fresh();
         if (r.op == dllm_pkg::OP_INS_AFTER) r.anchor = any_member();
      end else if (roll < 92) begin
         // bad node handle
         case ($urandom_range(0, 3))
            0:       r.op = dllm_pkg::OP_INS_TAIL;
            1:       r.op = dllm_pkg::OP_INS_HEAD;
            2:       r.op = dllm_pkg::OP_INS_AFTER;
            default: r.op = dllm_pkg::OP_UNLINK;
         endcase
         r.node = '0;
      end else begin
         r.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      end
      return r;
   endfunction

   // drive one transaction, predict its response once accepted, then maybe idle
   task automatic send_op(input dllm_pkg::req_type r, input logic known,
                          input dllm_pkg::rsp_type typed);
      dllm_pkg::rsp_type got;
      int unsigned       gap;
      calm      <= (issued >= 200 && issued < 280);
      issued++;
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (!req_ready);

      got = apply_list_op(r);
      due_results.push_back(known ? typed : got);

      // keep the stimulus view of the list roughly in step
      case (r.op)
         dllm_pkg::OP_INS_TAIL, dllm_pkg::OP_INS_HEAD, dllm_pkg::OP_INS_AFTER: begin
            if (handle_ok(r.node)) begin
               written[r.node] = 1'b1;
               add_member(r.node);
            end
         end
         dllm_pkg::OP_REM_TAIL, dllm_pkg::OP_REM_HEAD: begin
            if (got.got_one) drop_member(got.removed_node);
         end
         dllm_pkg::OP_UNLINK: begin
            if (handle_ok(r.node)) drop_member(r.node);
         end
         default: ;
      endcase
      if (list_empty()) begin
         while (member_q.size() != 0) begin
            on_list[member_q[0]] = 1'b0;
            void'(member_q.pop_front());
         end
      end

      gap = 0;
      while (!calm && $urandom_range(0, 99) < 17) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(input load_mode_type mode);
      dllm_pkg::req_type r;
      do r = pick_item(mode); while (!reads_only_written(r));
      send_op(r, 1'b0, ANY_RSP);
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 17);
   end

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      dllm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $error("response with none outstanding: %p", rsp_item);
            errors++;
         end else begin
            want = due_results.pop_front();
            if (rsp_item.was_empty !== want.was_empty) begin
               $error("was_empty: expected %0d, got %0d", want.was_empty, rsp_item.was_empty);
               errors++;
            end
            if (rsp_item.got_one !== want.got_one) begin
               $error("got_one: expected %0d, got %0d", want.got_one, rsp_item.got_one);
               errors++;
            end
            if (rsp_item.removed_node !== want.removed_node) begin
               $error("removed_node: expected %0d, got %0d",
                      want.removed_node, rsp_item.removed_node);
               errors++;
            end
            if (rsp_item.element_count !== want.element_count) begin
               $error("element_count: expected %0d, got %0d",
                      want.element_count, rsp_item.element_count);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // reset, directed sequence, random phases, final check
   initial begin
      int unsigned extra;
      int unsigned fill_items;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_LEN; i++) send_op(PLAN[i].item, PLAN[i].known, PLAN[i].want);

      repeat (MIXED_ITEMS) send_random(MIXED);

      // fill until the count saturates, then push a few more inserts
      extra      = 0;
      fill_items = 0;
      while (extra < FILL_EXTRA && fill_items < FILL_CAP) begin
         send_random(FILLING);
         if (linked_count == dllm_pkg::COUNT_MAX) extra++;
         fill_items++;
      end

      repeat (DRAIN_ITEMS) send_random(DRAINING);

      if (req_valid) req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      if (due_results.size() != 0) begin
         $error("%0d responses never arrived", due_results.size());
         errors++;
      end
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> doubly_linked_list_manager.f
design/dllm_pkg.sv
design/dllm_ram.sv
design/dllm_engine.sv
design/doubly_linked_list_manager.sv
tb/sv/doubly_linked_list_manager_tb.sv
